// ===== design/sli_pkg.sv =====
package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int VAL_W    = 8;
	localparam int CNT_O_W  = 5;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_DONE      = 2'd0,
		STATUS_NOT_FOUND = 2'd1,
		STATUS_FULL      = 2'd2,
		STATUS_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_TAIL,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic             action;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [CNT_O_W-1:0] entry_count;
		logic [VAL_W-1:0]   smallest_value;
	} res_t;

endpackage

// ===== design/sli_ram.sv =====
module sli_ram #(
	parameter int DEPTH = sli_pkg::CAPACITY,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [sli_pkg::VAL_W-1:0] rd_data,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [sli_pkg::VAL_W-1:0] wr_data
);

	logic [sli_pkg::VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/sorted_list_insert_delete.sv =====
// flow: a refused insert, an insert into an empty list or a delete on an empty list
// goes straight to the result; otherwise a delete walks the held entries, an insert walks
// them and then writes the tail, one pass over the value memory at one entry a cycle
// throughput: one request in flight; the next is taken the cycle after the result loads
// reset: count cleared, value memory not cleared (only entries below the count are read)
module sorted_list_insert_delete #(
	parameter int CAPACITY = sli_pkg::CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sli_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output sli_pkg::res_t res
);

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	sli_pkg::state_t  state_q, state_d;
	sli_pkg::status_t status_q, status_d;
	logic                      act_q, act_d;
	logic [sli_pkg::VAL_W-1:0] val_q, val_d;
	logic [AW-1:0]             ptr_q, ptr_d;
	logic [sli_pkg::VAL_W-1:0] carry_q, carry_d;
	logic                      hit_q, hit_d;
	logic [CNT_W-1:0]          count_q, count_d;
	logic [sli_pkg::VAL_W-1:0] head_q, head_d;
	logic                      res_valid_q;
	sli_pkg::res_t             res_q;

	logic                      rd_en, wr_en;
	logic [AW-1:0]             rd_addr, wr_addr;
	logic [sli_pkg::VAL_W-1:0] rd_data, wr_data;

	logic accept, load, last, hit_now;

	sli_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign req_ready = (state_q == sli_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign load      = (state_q == sli_pkg::ST_FIN) && (!res_valid_q || res_ready);
	assign last      = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
	assign hit_now   = (act_q == sli_pkg::ACT_DELETE) ? (rd_data == val_q)
	                                                  : (val_q <= rd_data);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sli_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.action == sli_pkg::ACT_DELETE) begin
						state_d = (count_q == '0) ? sli_pkg::ST_FIN : sli_pkg::ST_WALK;
					end else begin
						state_d = (count_q == FULL_CNT || count_q == '0) ?
							sli_pkg::ST_FIN : sli_pkg::ST_WALK;
					end
				end
			end
			sli_pkg::ST_WALK: begin
				if (last) begin
					state_d = (act_q == sli_pkg::ACT_DELETE) ? sli_pkg::ST_FIN
					                                         : sli_pkg::ST_TAIL;
				end
			end
			sli_pkg::ST_TAIL: state_d = sli_pkg::ST_FIN;
			sli_pkg::ST_FIN: begin
				if (load) begin
					state_d = sli_pkg::ST_IDLE;
				end
			end
			default: state_d = sli_pkg::ST_IDLE;
		endcase
	end

	// datapath and memory control
	always_comb begin
		status_d = status_q;
		act_d    = act_q;
		val_d    = val_q;
		ptr_d    = ptr_q;
		carry_d  = carry_q;
		hit_d    = hit_q;
		count_d  = count_q;
		head_d   = head_q;
		rd_en    = 1'b0;
		rd_addr  = ptr_q;
		wr_en    = 1'b0;
		wr_addr  = ptr_q;
		wr_data  = val_q;
		case (state_q)
			sli_pkg::ST_IDLE: begin
				if (accept) begin
					act_d   = req.action;
					val_d   = req.value;
					ptr_d   = '0;
					hit_d   = 1'b0;
					rd_addr = '0;
					status_d = sli_pkg::STATUS_DONE;
					if (req.action == sli_pkg::ACT_DELETE) begin
						if (count_q == '0) begin
							status_d = sli_pkg::STATUS_EMPTY;
						end else begin
							rd_en = 1'b1;
						end
					end else if (count_q == FULL_CNT) begin
						status_d = sli_pkg::STATUS_FULL;
					end else if (count_q == '0) begin
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = req.value;
						head_d  = req.value;
						count_d = CNT_W'(1);
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			sli_pkg::ST_WALK: begin
				hit_d = hit_q || hit_now;
				if (act_q == sli_pkg::ACT_DELETE) begin
					// close the gap behind the removed entry
					if (hit_q) begin
						wr_en   = 1'b1;
						wr_addr = ptr_q - AW'(1);
						wr_data = rd_data;
					end
					if (last) begin
						if (hit_q || hit_now) begin
							count_d  = count_q - CNT_W'(1);
							status_d = sli_pkg::STATUS_DONE;
						end else begin
							status_d = sli_pkg::STATUS_NOT_FOUND;
						end
					end
				end else if (hit_q || hit_now) begin
					wr_en   = 1'b1;
					wr_addr = ptr_q;
					wr_data = hit_q ? carry_q : val_q;
					carry_d = rd_data;
				end
				if (wr_en && wr_addr == '0) begin
					head_d = wr_data;
				end
				if (!last) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q + AW'(1);
					ptr_d   = ptr_q + AW'(1);
				end
			end
			sli_pkg::ST_TAIL: begin
				wr_en    = 1'b1;
				wr_addr  = count_q[AW-1:0];
				wr_data  = hit_q ? carry_q : val_q;
				count_d  = count_q + CNT_W'(1);
				status_d = sli_pkg::STATUS_DONE;
			end
			sli_pkg::ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sli_pkg::ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		act_q    <= act_d;
		val_q    <= val_d;
		ptr_q    <= ptr_d;
		carry_q  <= carry_d;
		hit_q    <= hit_d;
		head_q   <= head_d;
		if (load) begin
			res_q.status         <= status_q;
			res_q.entry_count    <= sli_pkg::CNT_O_W'(count_q);
			res_q.smallest_value <= (count_q == '0) ? '0 : head_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("count above capacity");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sli_pkg::ST_WALK) |-> (CNT_W'(ptr_q) < count_q))
		else $error("walk pointer beyond held entries");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != sli_pkg::ST_IDLE))
		else $error("accepted request did not start");

	a_tail_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sli_pkg::ST_TAIL) |-> (count_q < FULL_CNT))
		else $error("insert tail write on full list");

endmodule

// ===== sim/sorted_list_checker.sv =====
module sorted_list_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  sli_pkg::req_t req,
	input  logic          res_valid,
	input  logic          res_ready,
	input  sli_pkg::res_t res,
	output int            fail_count,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sli_pkg::*;

	logic [VAL_W-1:0] sorted_vals[CAPACITY];
	int               held_n;
	res_t             expected_results[$];
	res_t             want;
	int               errs = 0;

	// applies one request to the local copy of the store, returns the result it causes
	function automatic res_t update_store(input req_t r);
		res_t    o;
		status_t st;
		int      pos;
		st  = STATUS_DONE;
		pos = 0;
		if (r.action == ACT_INSERT) begin
			if (held_n >= CAPACITY) begin
				st = STATUS_FULL;
			end else begin
				while (pos < held_n && r.value > sorted_vals[pos])
					pos++;
				for (int i = held_n; i > pos; i--)
					sorted_vals[i] = sorted_vals[i-1];
				sorted_vals[pos] = r.value;
				held_n++;
			end
		end else begin
			if (held_n == 0) begin
				st = STATUS_EMPTY;
			end else begin
				while (pos < held_n && sorted_vals[pos] != r.value)
					pos++;
				if (pos >= held_n) begin
					st = STATUS_NOT_FOUND;
				end else begin
					for (int i = pos; i + 1 < held_n; i++)
						sorted_vals[i] = sorted_vals[i+1];
					held_n--;
				end
			end
		end
		o.status         = st;
		o.entry_count    = CNT_O_W'(held_n);
		o.smallest_value = (held_n > 0) ? sorted_vals[0] : '0;
		return o;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			held_n = 0;
			expected_results.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d entry_count %0d smallest_value %0d",
						res.status, res.entry_count, res.smallest_value);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						errs++;
					end
					if (res.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d",
							want.entry_count, res.entry_count);
						errs++;
					end
					if (res.smallest_value !== want.smallest_value) begin
						$error("smallest_value: expected %0d, got %0d",
							want.smallest_value, res.smallest_value);
						errs++;
					end
				end
			end
			if (req_valid && req_ready)
				expected_results.push_back(update_store(req));
		end
		pending    <= expected_results.size();
		fail_count <= errs;
	end

endmodule

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sli_pkg::*;

	localparam int RANDOM_ITEMS   = 1450;
	localparam int CYCLE_LIMIT    = 1000000;
	localparam int HOLDOFF_AT     = 400;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int TAIL_CYCLES    = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic res_valid;
	logic res_ready;
	res_t res;
	int   fail_count;
	int   pending;
	int   cycles = 0;
	int   calm_left = 0;
	logic [VAL_W-1:0] recent_vals[$];

	always #5ns clk = ~clk;

	sorted_list_insert_delete dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	sorted_list_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value(input bit narrow,
		input logic [VAL_W-1:0] base);
		int r;
		r = $urandom_range(99);
		if (r < 4)
			return '0;
		if (r < 8)
			return '1;
		if (narrow)
			return base + VAL_W'($urandom_range(7));
		return VAL_W'($urandom_range(255));
	endfunction

	// one request, then maybe an idle gap
	task automatic offer(input logic act, input logic [VAL_W-1:0] val);
		int n;
		req_valid <= 1'b1;
		req       <= '{action: act, value: val};
		do @(posedge clk); while (!req_ready);
		if (calm_left > 0) begin
			calm_left--;
		end else if ($urandom_range(99) < 35) begin
			n = gap_len();
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end else if ($urandom_range(99) < 5) begin
			calm_left = $urandom_range(20, 80);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("sorted_list_insert_delete regression: fail");
			$finish;
		end
	end

	// result side
	initial begin
		int stall_left;
		int quiet_left;
		int taken;
		stall_left = 0;
		quiet_left = 0;
		taken      = 0;
		res_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_valid && res_ready) begin
				taken++;
				if (taken == HOLDOFF_AT)
					stall_left = HOLDOFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if (quiet_left > 0)
					quiet_left--;
				else if ($urandom_range(99) < 30)
					stall_left = gap_len();
				else if ($urandom_range(99) < 4)
					quiet_left = $urandom_range(30, 120);
			end
		end
	end

	// request side and verdict
	initial begin
		int               ins_pct;
		bit               narrow;
		logic [VAL_W-1:0] base;
		logic [VAL_W-1:0] v;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		ins_pct = 50;
		narrow  = 1'b0;
		base    = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(ACT_DELETE, 8'd5);
		offer(ACT_INSERT, 8'd255);
		offer(ACT_INSERT, 8'd0);
		offer(ACT_INSERT, 8'd128);
		offer(ACT_INSERT, 8'd128);
		offer(ACT_DELETE, 8'd7);
		offer(ACT_DELETE, 8'd128);
		offer(ACT_DELETE, 8'd255);
		for (int k = 0; k < CAPACITY - 2; k++)
			offer(ACT_INSERT, VAL_W'(k * 17 + 3));
		offer(ACT_INSERT, 8'd1);
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0) begin
				ins_pct = 20 + 30 * $urandom_range(2);
				narrow  = $urandom_range(1);
				base    = VAL_W'($urandom_range(248));
			end
			if (n == RANDOM_ITEMS / 2)
				drain();
			if ($urandom_range(99) < ins_pct) begin
				v = pick_value(narrow, base);
				recent_vals.push_back(v);
				if (recent_vals.size() > 32)
					void'(recent_vals.pop_front());
				offer(ACT_INSERT, v);
			end else begin
				if (recent_vals.size() > 0 && $urandom_range(99) < 65)
					v = recent_vals[$urandom_range(recent_vals.size() - 1)];
				else
					v = pick_value(narrow, base);
				offer(ACT_DELETE, v);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_list_insert_delete regression: pass");
		else
			$display("sorted_list_insert_delete regression: fail");
		$finish;
	end

endmodule
